// File: sv/pps_pkg.sv
`timescale 1ns / 1ps
package pps_pkg;

  localparam int NUM_TASKS = 64;
  localparam int SLOT_W    = $clog2(NUM_TASKS);
  localparam int PID_W     = 7;
  localparam int RET_W     = 8;
  localparam int CODE_W    = 8;
  localparam int NICE_IN_W = 8;
  localparam int NICE_W    = 6;
  localparam int CPU_W     = 16;
  localparam int TIME_W    = 32;
  localparam int STAT_W    = 3;
  // priority is 1..40, the divisor 20 - nice is 1..40
  localparam int PRI_W     = 6;
  // dividend below divisor squared (at most 1599), quotient below 40
  localparam int DIV_W     = 11;
  localparam int SQ_W      = 12;
  localparam int STEP_W    = 3;
  localparam int DIV_STEPS = 6;

  localparam int PRI_BASE = 20;
  localparam int NICE_MAX = 19;
  localparam int NICE_MIN = -20;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOCHILD = 3'd2;
  localparam logic [STAT_W-1:0] STAT_BLOCKED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_IDLE    = 3'd4;

  typedef enum logic [1:0] {
    ST_READY    = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_SLEEPING = 2'd2,
    ST_ZOMBIE   = 2'd3
  } tstate_t;

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0,
    CMD_FORK = 3'd1,
    CMD_EXIT = 3'd2,
    CMD_WAIT = 3'd3,
    CMD_NICE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    SCAN_PRI,
    SCAN_FREE,
    SCAN_CHILD
  } scan_mode_t;

  typedef struct packed {
    logic                     used;
    tstate_t                  state;
    logic [SLOT_W-1:0]        parent;
    logic signed [NICE_W-1:0] nice;
    logic [CPU_W-1:0]         recent;
    logic [TIME_W-1:0]        total;
    logic [CODE_W-1:0]        code;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_CAPCUR,
    OP_TICK,
    OP_IDLEST,
    OP_NICE,
    OP_EXIT,
    OP_PRD,
    OP_PWR,
    OP_SC_RD,
    OP_SC_EV,
    OP_DIV,
    OP_CMP,
    OP_RS_RDC,
    OP_RS_CLR,
    OP_RS_RDB,
    OP_RS_RUN,
    OP_WT_NOCH,
    OP_WT_REAP,
    OP_WT_SLEEP,
    OP_FK_DONE,
    OP_FK_FULL,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       sc_init;
    scan_mode_t mode;
    logic       adv;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       active;
    logic       elig;
    logic       big;
    logic       free_hit;
    logic       last;
    logic       div_last;
    logic       found;
    logic       best_is_cur;
    logic       any_child;
    logic       zfound;
    scan_mode_t mode;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CUR,
    S_DISP,
    S_PAR_RD,
    S_PAR_WR,
    S_SC_RD,
    S_SC_EV,
    S_SC_DIV,
    S_SC_CMP,
    S_SC_END,
    S_RS_CHK,
    S_RS_CLR,
    S_RS_RDB,
    S_RS_RUN,
    S_DONE
  } ctl_state_t;

  // contents of a slot that was never written since reset
  function automatic entry_t reset_entry(input logic [SLOT_W-1:0] slot);
    entry_t e;
    e = '0;
    if (slot == '0) begin
      e.used  = 1'b1;
      e.state = ST_RUNNING;
    end
    return e;
  endfunction

endpackage

// File: sv/pps_ram.sv
`timescale 1ns / 1ps
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/pps_ctrl.sv
`timescale 1ns / 1ps
module pps_ctrl import pps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t st,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       ev_div, ev_cmp, ev_hit;

  assign out_free = !out_valid_r || out_tready;
  assign ev_div   = (st.mode == SCAN_PRI) && st.elig && !st.big;
  assign ev_cmp   = (st.mode == SCAN_PRI) && st.elig && st.big;
  assign ev_hit   = (st.mode == SCAN_FREE) && st.free_hit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_CUR;
      S_CUR:    state_nxt = S_DISP;
      S_DISP: begin
        unique case (st.cmd)
          CMD_TICK: state_nxt = S_SC_RD;
          CMD_FORK: state_nxt = st.active ? S_SC_RD : S_DONE;
          CMD_EXIT: state_nxt = st.active ? S_PAR_RD : S_DONE;
          CMD_WAIT: state_nxt = st.active ? S_SC_RD : S_DONE;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_PAR_RD: state_nxt = S_PAR_WR;
      S_PAR_WR: state_nxt = S_SC_RD;
      S_SC_RD:  state_nxt = S_SC_EV;
      S_SC_EV: begin
        if (ev_div) state_nxt = S_SC_DIV;
        else if (ev_cmp) state_nxt = S_SC_CMP;
        else if (ev_hit || st.last) state_nxt = S_SC_END;
        else state_nxt = S_SC_RD;
      end
      S_SC_DIV: if (st.div_last) state_nxt = S_SC_CMP;
      S_SC_CMP: state_nxt = st.last ? S_SC_END : S_SC_RD;
      S_SC_END: begin
        unique case (st.mode)
          SCAN_PRI:   state_nxt = S_RS_CHK;
          SCAN_CHILD: state_nxt = (st.any_child && !st.zfound) ? S_SC_RD : S_DONE;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_RS_CHK: begin
        if (!st.found) state_nxt = S_DONE;
        else if (st.best_is_cur) state_nxt = S_RS_RDB;
        else state_nxt = S_RS_CLR;
      end
      S_RS_CLR: state_nxt = S_RS_RDB;
      S_RS_RDB: state_nxt = S_RS_RUN;
      S_RS_RUN: state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: OP_NONE, sc_init: 1'b0, mode: SCAN_PRI, adv: 1'b0};
    unique case (state_r)
      S_IDLE:   if (in_tvalid) cmd.op = OP_START;
      S_CUR:    cmd.op = OP_CAPCUR;
      S_DISP: begin
        unique case (st.cmd)
          CMD_TICK: begin
            cmd.op      = OP_TICK;
            cmd.sc_init = 1'b1;
          end
          CMD_FORK: begin
            cmd.op      = st.active ? OP_NONE : OP_IDLEST;
            cmd.sc_init = st.active;
            cmd.mode    = SCAN_FREE;
          end
          CMD_EXIT: cmd.op = st.active ? OP_EXIT : OP_IDLEST;
          CMD_WAIT: begin
            cmd.op      = st.active ? OP_NONE : OP_IDLEST;
            cmd.sc_init = st.active;
            cmd.mode    = SCAN_CHILD;
          end
          CMD_NICE: cmd.op = st.active ? OP_NICE : OP_IDLEST;
          default:  cmd.op = OP_NONE;
        endcase
      end
      S_PAR_RD: cmd.op = OP_PRD;
      S_PAR_WR: begin
        cmd.op      = OP_PWR;
        cmd.sc_init = 1'b1;
      end
      S_SC_RD:  cmd.op = OP_SC_RD;
      S_SC_EV: begin
        cmd.op  = OP_SC_EV;
        cmd.adv = !(ev_div || ev_cmp || ev_hit || st.last);
      end
      S_SC_DIV: cmd.op = OP_DIV;
      S_SC_CMP: begin
        cmd.op  = OP_CMP;
        cmd.adv = !st.last;
      end
      S_SC_END: begin
        unique case (st.mode)
          SCAN_FREE:  cmd.op = st.found ? OP_FK_DONE : OP_FK_FULL;
          SCAN_CHILD: begin
            if (!st.any_child) begin
              cmd.op = OP_WT_NOCH;
            end else if (st.zfound) begin
              cmd.op = OP_WT_REAP;
            end else begin
              cmd.op      = OP_WT_SLEEP;
              cmd.sc_init = 1'b1;
            end
          end
          default:    cmd.op = OP_NONE;
        endcase
      end
      S_RS_CHK: begin
        if (!st.found) cmd.op = OP_IDLEST;
        else if (!st.best_is_cur) cmd.op = OP_RS_RDC;
      end
      S_RS_CLR: cmd.op = OP_RS_CLR;
      S_RS_RDB: cmd.op = OP_RS_RDB;
      S_RS_RUN: cmd.op = OP_RS_RUN;
      S_DONE:   if (out_free) cmd.op = OP_OUT;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (state_r == S_DONE && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// File: sv/pps_dp.sv
`timescale 1ns / 1ps
module pps_dp import pps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           in_command,
  input  logic [CODE_W-1:0]    in_exit_code,
  input  logic [NICE_IN_W-1:0] in_nice_value,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             st,
  output logic [PID_W-1:0]     out_pid,
  output logic [RET_W-1:0]     out_ret,
  output logic [STAT_W-1:0]    out_status,
  output logic                 out_switched
);

  // event registers
  cmd_t                  cmd_r;
  logic [CODE_W-1:0]     code_r;
  logic [NICE_IN_W-1:0]  nice_r;

  // scheduler state
  logic [SLOT_W-1:0]     cur_r;
  logic [TIME_W-1:0]     tick_r;
  entry_t                cur_ent_r;
  logic [NUM_TASKS-1:0]  vld_r;

  // scan state
  scan_mode_t            mode_r;
  logic [SLOT_W-1:0]     idx_r;
  logic                  found_r;
  logic [SLOT_W-1:0]     best_r;
  logic [PRI_W-1:0]      best_pri_r;
  logic                  any_r;
  logic                  zfound_r;
  logic [SLOT_W-1:0]     zidx_r;
  logic [CODE_W-1:0]     zcode_r;

  // divider
  logic [PRI_W-1:0]      d_r;
  logic [DIV_W-1:0]      rem_r;
  logic [PRI_W-1:0]      q_r;
  logic [STEP_W-1:0]     step_r;
  logic                  big_r;

  // result
  logic [RET_W-1:0]      ret_r;
  logic [STAT_W-1:0]     stat_r;
  logic                  chg_r;
  logic [PID_W-1:0]      out_pid_r;
  logic [RET_W-1:0]      out_ret_r;
  logic [STAT_W-1:0]     out_stat_r;
  logic                  out_sw_r;

  // memory port
  logic                  re, we;
  logic [SLOT_W-1:0]     raddr, waddr;
  entry_t                wdata;
  logic [ENTRY_W-1:0]    rdata;
  logic [SLOT_W-1:0]     rd_addr_r;
  logic                  rd_vld_r;
  entry_t                rd_ent;

  entry_t                tick_ent, child_ent;
  logic [PRI_W:0]        d_full;
  logic [PRI_W-1:0]      d_ev;
  logic [SQ_W-1:0]       dsq;
  logic [DIV_W-1:0]      dsh;
  logic [PRI_W-1:0]      pri;
  logic signed [NICE_W-1:0] nice_clamp;
  logic                  is_child;

  pps_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TASKS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ent = rd_vld_r ? entry_t'(rdata) : reset_entry(rd_addr_r);

  // priority terms
  assign d_full = PRI_W'(PRI_BASE) - {rd_ent.nice[NICE_W-1], rd_ent.nice};
  assign d_ev   = d_full[PRI_W-1:0];
  assign dsq    = {{(SQ_W-PRI_W){1'b0}}, d_ev} * {{(SQ_W-PRI_W){1'b0}}, d_ev};
  assign dsh    = {{(DIV_W-PRI_W){1'b0}}, d_r} << step_r;
  assign pri    = big_r ? PRI_W'(1) : d_r - q_r;

  assign is_child = rd_ent.used && (idx_r != cur_r) && (rd_ent.parent == cur_r);

  always_comb begin
    if ($signed(nice_r) > NICE_MAX) nice_clamp = NICE_W'(NICE_MAX);
    else if ($signed(nice_r) < NICE_MIN) nice_clamp = NICE_W'(NICE_MIN);
    else nice_clamp = nice_r[NICE_W-1:0];
  end

  always_comb begin
    tick_ent = cur_ent_r;
    if (cur_ent_r.state == ST_RUNNING) begin
      tick_ent.state = ST_READY;
      if (cur_ent_r.total != '1) tick_ent.total = cur_ent_r.total + 1'b1;
      if (cur_ent_r.recent != '1) tick_ent.recent = cur_ent_r.recent + 1'b1;
    end
  end

  always_comb begin
    child_ent        = '0;
    child_ent.used   = 1'b1;
    child_ent.state  = ST_READY;
    child_ent.parent = cur_r;
    child_ent.recent = cur_ent_r.recent;
    child_ent.total  = cur_ent_r.total;
  end

  always_comb begin
    re    = 1'b0;
    raddr = cur_r;
    we    = 1'b0;
    waddr = cur_r;
    wdata = cur_ent_r;
    unique case (cmd.op)
      OP_START:  re = 1'b1;
      OP_PRD: begin
        re    = 1'b1;
        raddr = cur_ent_r.parent;
      end
      OP_SC_RD: begin
        re    = 1'b1;
        raddr = idx_r;
      end
      OP_RS_RDC: re = 1'b1;
      OP_RS_RDB: begin
        re    = 1'b1;
        raddr = best_r;
      end
      OP_TICK: begin
        we    = 1'b1;
        wdata = tick_ent;
      end
      OP_NICE: begin
        we         = 1'b1;
        wdata.nice = nice_clamp;
      end
      OP_EXIT: begin
        we          = 1'b1;
        wdata.state = ST_ZOMBIE;
        wdata.code  = code_r;
      end
      OP_PWR: begin
        we          = rd_ent.used && (rd_ent.state == ST_SLEEPING);
        waddr       = rd_addr_r;
        wdata       = rd_ent;
        wdata.state = ST_READY;
      end
      OP_RS_CLR: begin
        we           = 1'b1;
        wdata        = rd_ent;
        wdata.recent = '0;
      end
      OP_RS_RUN: begin
        we          = 1'b1;
        waddr       = best_r;
        wdata       = rd_ent;
        wdata.state = ST_RUNNING;
      end
      OP_WT_REAP: begin
        we    = 1'b1;
        waddr = zidx_r;
        wdata = '0;
      end
      OP_WT_SLEEP: begin
        we          = 1'b1;
        wdata.state = ST_SLEEPING;
      end
      OP_FK_DONE: begin
        we    = 1'b1;
        waddr = best_r;
        wdata = child_ent;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      cur_r  <= '0;
      tick_r <= '0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      if (cmd.op == OP_TICK && tick_r != '1) tick_r <= tick_r + 1'b1;
      if (cmd.op == OP_RS_RUN) cur_r <= best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_addr_r <= raddr;
      rd_vld_r  <= vld_r[raddr];
    end

    if (cmd.sc_init) begin
      mode_r   <= cmd.mode;
      idx_r    <= '0;
      found_r  <= 1'b0;
      any_r    <= 1'b0;
      zfound_r <= 1'b0;
    end
    if (cmd.adv) idx_r <= idx_r + 1'b1;

    unique case (cmd.op)
      OP_START: begin
        cmd_r  <= cmd_t'(in_command);
        code_r <= in_exit_code;
        nice_r <= in_nice_value;
        ret_r  <= '0;
        stat_r <= STAT_OK;
        chg_r  <= 1'b0;
      end
      OP_CAPCUR: cur_ent_r <= rd_ent;
      OP_IDLEST: stat_r <= STAT_IDLE;
      OP_SC_EV: begin
        unique case (mode_r)
          SCAN_PRI: begin
            d_r    <= d_ev;
            rem_r  <= rd_ent.recent[DIV_W-1:0];
            q_r    <= '0;
            step_r <= STEP_W'(DIV_STEPS - 1);
            big_r  <= rd_ent.recent >= {{(CPU_W-SQ_W){1'b0}}, dsq};
          end
          SCAN_FREE: begin
            if (!rd_ent.used) begin
              found_r <= 1'b1;
              best_r  <= idx_r;
            end
          end
          default: begin
            if (is_child) begin
              any_r <= 1'b1;
              if (rd_ent.state == ST_ZOMBIE && !zfound_r) begin
                zfound_r <= 1'b1;
                zidx_r   <= idx_r;
                zcode_r  <= rd_ent.code;
              end
            end
          end
        endcase
      end
      OP_DIV: begin
        if (rem_r >= dsh) begin
          rem_r        <= rem_r - dsh;
          q_r[step_r]  <= 1'b1;
        end
        step_r <= step_r - 1'b1;
      end
      OP_CMP: begin
        if (!found_r || pri > best_pri_r) begin
          found_r    <= 1'b1;
          best_r     <= idx_r;
          best_pri_r <= pri;
        end
      end
      OP_RS_RUN:   chg_r <= (best_r != cur_r);
      OP_WT_NOCH:  stat_r <= STAT_NOCHILD;
      OP_WT_REAP:  ret_r <= zcode_r;
      OP_WT_SLEEP: stat_r <= STAT_BLOCKED;
      OP_FK_DONE:  ret_r <= RET_W'({1'b0, best_r} + 1'b1);
      OP_FK_FULL:  stat_r <= STAT_FULL;
      OP_OUT: begin
        out_pid_r  <= PID_W'({1'b0, cur_r} + 1'b1);
        out_ret_r  <= ret_r;
        out_stat_r <= stat_r;
        out_sw_r   <= chg_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.cmd         = cmd_r;
    st.active      = (cur_ent_r.state == ST_RUNNING);
    st.elig        = rd_ent.used && (rd_ent.state == ST_READY);
    st.big         = rd_ent.recent >= {{(CPU_W-SQ_W){1'b0}}, dsq};
    st.free_hit    = !rd_ent.used;
    st.last        = (idx_r == SLOT_W'(NUM_TASKS - 1));
    st.div_last    = (step_r == '0);
    st.found       = found_r;
    st.best_is_cur = (best_r == cur_r);
    st.any_child   = any_r;
    st.zfound      = zfound_r;
    st.mode        = mode_r;
  end

  assign out_pid      = out_pid_r;
  assign out_ret      = out_ret_r;
  assign out_status   = out_stat_r;
  assign out_switched = out_sw_r;

endmodule

// File: sv/priority_process_scheduler.sv
`timescale 1ns / 1ps
// Task scheduler with a 64-slot task table held in one RAM. Each input item is
// one event for the current task (tick, fork, exit, wait, set nice) and gives
// exactly one result item. Events are processed one at a time: the block takes
// a new item only once the previous one is finished, while the finished result
// may still sit in the output register. Latency is set by sequential sweeps of
// the task table through the single RAM port: a fork or a wait sweep reads and
// checks one slot at a time; a reschedule (tick, exit, blocking wait) also runs,
// for each ready slot, up to 6 steps of the bit-serial priority divider and a
// compare. Nice and ignored events need no sweep of the table. No clearing pass
// is needed after reset: per-slot valid flops stand in for reset values.
module priority_process_scheduler import pps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // exit_code[7:0], nice_value[15:8]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // running_pid[6:0], return_value[14:7], switched[15]
  output logic [2:0]  out_tuser   // status[2:0]
);

  ctl_cmd_t           cmd;
  dp_stat_t           st;
  logic [PID_W-1:0]   pid;
  logic [RET_W-1:0]   ret;
  logic [STAT_W-1:0]  status;
  logic               switched;

  // sequence each event through the table
  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  // hold the table, scan state, divider and result register
  pps_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_tuser),
    .in_exit_code  (in_tdata[7:0]),
    .in_nice_value (in_tdata[15:8]),
    .cmd           (cmd),
    .st            (st),
    .out_pid       (pid),
    .out_ret       (ret),
    .out_status    (status),
    .out_switched  (switched)
  );

  assign out_tdata = {switched, ret, pid};
  assign out_tuser = status;

  // one event at a time: after an accept, hold off the next item
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an event is in progress");

  // a task switch comes only from a successful reschedule
  a_switch_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[15]) |-> (out_tuser == STAT_OK || out_tuser == STAT_BLOCKED))
    else $error("switch reported with an error status");

  // a return value is given only with an ok status
  a_ret_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != STAT_OK) |-> (out_tdata[14:7] == '0))
    else $error("return value given with a failing status");

  // no new result while the decision for the current item is still in flight
  a_out_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("pending result lost on accept");

endmodule
